// ----- src/q2e_pkg.sv -----
// Shared widths, constants and types for the quaternion to Euler angle unit.
package q2e_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int TAB_LEN = 24;
  localparam int XW = 40;   // CORDIC vector width
  localparam int AW = 36;   // angle width, units of 2^-30 rad
  localparam int SW = 32;   // asin argument width
  localparam int CW = 31;   // asin cosine width
  localparam int QW = 16;
  localparam int THR_W = 31;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_DEGREES_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_THR    = 2'd1;
  localparam logic [THR_W-1:0]     PITCH_THR_RESET  = 31'd536870375;

  localparam logic signed [XW-1:0] ONE_Q30     = 40'sd1073741824;
  localparam logic signed [AW-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [AW-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [22:0]   DEG_PER_RAD_Q16 = 23'sd3754936;

  typedef struct packed {
    logic signed [XW-1:0] y;
    logic signed [XW-1:0] x;
  } vec_t;

  typedef struct packed {
    logic clamped;
    logic neg;
  } pctl_t;

  typedef struct packed {
    vec_t                 roll;
    vec_t                 yaw;
    logic signed [SW-1:0] s;
    pctl_t                ctl;
  } side_t;

  // atan(2^-i) in Q30, truncated
  function automatic logic signed [AW-1:0] atan_entry(input int i);
    logic [31:0] v;
    case (i)
      0:  v = 32'h3243F6A8;
      1:  v = 32'h1DAC6705;
      2:  v = 32'h0FADBAFC;
      3:  v = 32'h07F56EA6;
      4:  v = 32'h03FEAB76;
      5:  v = 32'h01FFD55B;
      6:  v = 32'h00FFFAAA;
      7:  v = 32'h007FFF55;
      8:  v = 32'h003FFFEA;
      9:  v = 32'h001FFFFD;
      10: v = 32'h000FFFFF;
      11: v = 32'h0007FFFF;
      12: v = 32'h0003FFFF;
      13: v = 32'h0001FFFF;
      14: v = 32'h0000FFFF;
      15: v = 32'h00007FFF;
      16: v = 32'h00003FFF;
      17: v = 32'h00001FFF;
      18: v = 32'h00000FFF;
      19: v = 32'h000007FF;
      20: v = 32'h000003FF;
      21: v = 32'h000001FF;
      22: v = 32'h000000FF;
      23: v = 32'h0000007F;
      default: v = 32'h0;
    endcase
    return AW'($signed({1'b0, v}));
  endfunction

endpackage

// ----- src/q2e_front.sv -----
// Front end: quaternion products, atan2 operands, asin argument and clamp test.
module q2e_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          vld_in,
  input  logic signed [q2e_pkg::QW-1:0] w,
  input  logic signed [q2e_pkg::QW-1:0] x,
  input  logic signed [q2e_pkg::QW-1:0] y,
  input  logic signed [q2e_pkg::QW-1:0] z,
  input  logic [q2e_pkg::THR_W-1:0]     thr,
  output logic                          vld,
  output q2e_pkg::side_t                side
);
  import q2e_pkg::*;

  logic signed [2*QW-1:0] wz_r, xy_r, zz_r, xx_r, wy_r, xz_r, yy_r, wx_r, yz_r;
  logic                   vld1_r, vld2_r;
  side_t                  side_r, side_nxt;

  logic signed [XW-1:0] wz, xy, zz, xx, wy, xz, yy, wx, yz, p, thr_e, s2, s_sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (adv) begin
      vld1_r <= vld_in;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      wz_r <= w * z;
      xy_r <= x * y;
      zz_r <= z * z;
      xx_r <= x * x;
      wy_r <= w * y;
      xz_r <= x * z;
      yy_r <= y * y;
      wx_r <= w * x;
      yz_r <= y * z;
      side_r <= side_nxt;
    end
  end

  always_comb begin
    wz = XW'(wz_r);
    xy = XW'(xy_r);
    zz = XW'(zz_r);
    xx = XW'(xx_r);
    wy = XW'(wy_r);
    xz = XW'(xz_r);
    yy = XW'(yy_r);
    wx = XW'(wx_r);
    yz = XW'(yz_r);
    thr_e = XW'($signed({1'b0, thr}));
    p = wx - yz;
    s2 = p <<< 1;
    priority if (s2 > ONE_Q30) s_sat = ONE_Q30;
    else if (s2 < -ONE_Q30)    s_sat = -ONE_Q30;
    else                       s_sat = s2;
    side_nxt.roll.y = (wz + xy) <<< 1;
    side_nxt.roll.x = ONE_Q30 - ((zz + xx) <<< 1);
    side_nxt.yaw.y  = (wy + xz) <<< 1;
    side_nxt.yaw.x  = ONE_Q30 - ((xx + yy) <<< 1);
    side_nxt.s      = SW'(s_sat);
    side_nxt.ctl.neg     = (p < -thr_e);
    side_nxt.ctl.clamped = (p < -thr_e) || (p > thr_e);
  end

  assign vld  = vld2_r;
  assign side = side_r;

endmodule

// ----- src/q2e_isqrt.sv -----
// Pipelined exact square root of 1 - s^2, one result bit per stage.
module q2e_isqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          vld_in,
  input  logic signed [q2e_pkg::SW-1:0] s,
  output logic                          vld,
  output logic [q2e_pkg::CW-1:0]        c
);
  import q2e_pkg::*;

  localparam int DW = 62;
  localparam int NB = 31;

  logic signed [2*SW-1:0] sq_r;
  logic                   vsq_r;
  logic [DW-1:0]          d_a   [0:NB];
  logic [DW-1:0]          res_a [0:NB];
  logic                   vld_a [0:NB];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vsq_r    <= 1'b0;
      vld_a[0] <= 1'b0;
    end else if (adv) begin
      vsq_r    <= vld_in;
      vld_a[0] <= vsq_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_r     <= s * s;
      d_a[0]   <= (DW'(1) << 60) - DW'(sq_r);
      res_a[0] <= '0;
    end
  end

  for (genvar j = 0; j < NB; j++) begin : g_bit
    localparam logic [DW-1:0] BIT = DW'(1) << (2 * (NB - 1 - j));
    logic [DW-1:0] t;
    assign t = res_a[j] + BIT;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_a[j+1] <= 1'b0;
      end else if (adv) begin
        vld_a[j+1] <= vld_a[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        if (d_a[j] >= t) begin
          d_a[j+1]   <= d_a[j] - t;
          res_a[j+1] <= (res_a[j] >> 1) + BIT;
        end else begin
          d_a[j+1]   <= d_a[j];
          res_a[j+1] <= res_a[j] >> 1;
        end
      end
    end
  end

  assign vld = vld_a[NB];
  assign c   = res_a[NB][CW-1:0];

endmodule

// ----- src/q2e_cordic.sv -----
// Pipelined vectoring CORDIC: atan2(y, x) in units of 2^-30 rad.
module q2e_cordic #(
  parameter int NSTG = q2e_pkg::CORDIC_STAGES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          vld_in,
  input  q2e_pkg::vec_t                 v,
  output logic                          vld,
  output logic signed [q2e_pkg::AW-1:0] ang
);
  import q2e_pkg::*;

  logic signed [XW-1:0] x_a   [0:NSTG];
  logic signed [XW-1:0] y_a   [0:NSTG];
  logic signed [AW-1:0] ang_a [0:NSTG];
  logic                 zero_a[0:NSTG];
  logic                 vld_a [0:NSTG];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a[0] <= 1'b0;
    end else if (adv) begin
      vld_a[0] <= vld_in;
    end
  end

  // fold the left half plane onto the right one
  always_ff @(posedge clk) begin
    if (adv) begin
      zero_a[0] <= (v.x == '0) && (v.y == '0);
      if (v.x < 0) begin
        x_a[0]   <= -v.x;
        y_a[0]   <= -v.y;
        ang_a[0] <= (v.y >= 0) ? PI_Q30 : -PI_Q30;
      end else begin
        x_a[0]   <= v.x;
        y_a[0]   <= v.y;
        ang_a[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < NSTG; i++) begin : g_stg
    localparam logic signed [AW-1:0] TAB = atan_entry(i);
    logic signed [XW-1:0] xs, ys;
    assign xs = x_a[i] >>> i;
    assign ys = y_a[i] >>> i;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_a[i+1] <= 1'b0;
      end else if (adv) begin
        vld_a[i+1] <= vld_a[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        zero_a[i+1] <= zero_a[i];
        if (y_a[i] > 0) begin
          x_a[i+1]   <= x_a[i] + ys;
          y_a[i+1]   <= y_a[i] - xs;
          ang_a[i+1] <= ang_a[i] + TAB;
        end else begin
          x_a[i+1]   <= x_a[i] - ys;
          y_a[i+1]   <= y_a[i] + xs;
          ang_a[i+1] <= ang_a[i] - TAB;
        end
      end
    end
  end

  assign vld = vld_a[NSTG];
  assign ang = zero_a[NSTG] ? '0 : ang_a[NSTG];

endmodule

// ----- src/q2e_conv.sv -----
// Output scaling: radians Q3.13 or degrees Q9.7 with rounding and saturation.
module q2e_conv (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          vld_in,
  input  logic                          deg,
  input  logic signed [q2e_pkg::AW-1:0] pitch_in,
  input  logic signed [q2e_pkg::AW-1:0] yaw_in,
  input  logic signed [q2e_pkg::AW-1:0] roll_in,
  input  logic                          clamped_in,
  output logic                          vld,
  output logic signed [q2e_pkg::QW-1:0] pitch,
  output logic signed [q2e_pkg::QW-1:0] yaw,
  output logic signed [q2e_pkg::QW-1:0] roll,
  output logic                          clamped
);
  import q2e_pkg::*;

  localparam int PW = AW + 23;

  logic signed [AW-1:0] a_r [0:2];
  logic signed [PW-1:0] m_r [0:2];
  logic signed [QW-1:0] o_r [0:2];
  logic                 cl1_r, cl2_r, v1_r, v2_r;

  function automatic logic signed [QW-1:0] scale(input logic signed [AW-1:0] a,
                                                 input logic signed [PW-1:0] m,
                                                 input logic d);
    logic signed [PW-1:0] r;
    if (d) r = (m + (PW'(1) <<< 38)) >>> 39;
    else   r = PW'((a + (AW'(1) <<< 16)) >>> 17);
    priority if (r > PW'(32767)) return 16'sh7FFF;
    else if (r < -PW'(32768))    return 16'sh8000;
    else                         return r[QW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v1_r <= vld_in;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_r[0] <= pitch_in;
      a_r[1] <= yaw_in;
      a_r[2] <= roll_in;
      m_r[0] <= pitch_in * DEG_PER_RAD_Q16;
      m_r[1] <= yaw_in * DEG_PER_RAD_Q16;
      m_r[2] <= roll_in * DEG_PER_RAD_Q16;
      cl1_r  <= clamped_in;
      for (int k = 0; k < 3; k++) o_r[k] <= scale(a_r[k], m_r[k], deg);
      cl2_r  <= cl1_r;
    end
  end

  assign vld     = v2_r;
  assign pitch   = o_r[0];
  assign yaw     = o_r[1];
  assign roll    = o_r[2];
  assign clamped = cl2_r;

endmodule

// ----- src/quaternion_to_euler_angles_unit.sv -----
// Quaternion to Euler angle unit: top level with configuration registers.
// Fully pipelined converter: one quaternion can enter every clock cycle while
// the result channel is not stalled. Data passes through 2 front-end stages,
// the square root that feeds the pitch arctangent, the three parallel CORDIC
// pipelines and the scaling stages. A stall on the result channel freezes the
// whole pipeline and is passed back as in_stall. Pitch_clamped marks
// transactions where |wx - yz| exceeded the threshold and pitch was forced to
// +-pi/2. Write configuration only while no transaction is in flight.
module quaternion_to_euler_angles_unit #(
  parameter int CORDIC_STAGES = q2e_pkg::CORDIC_STAGES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [q2e_pkg::QW-1:0]     in_quat_w,
  input  logic signed [q2e_pkg::QW-1:0]     in_quat_x,
  input  logic signed [q2e_pkg::QW-1:0]     in_quat_y,
  input  logic signed [q2e_pkg::QW-1:0]     in_quat_z,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [q2e_pkg::QW-1:0]     out_pitch_angle,
  output logic signed [q2e_pkg::QW-1:0]     out_yaw_angle,
  output logic signed [q2e_pkg::QW-1:0]     out_roll_angle,
  output logic                              out_pitch_clamped,
  input  logic                              cfg_we,
  input  logic [q2e_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [q2e_pkg::THR_W-1:0]         cfg_data
);
  import q2e_pkg::*;

  localparam int SQ_LAT = 33;
  localparam int CD_LAT = CORDIC_STAGES + 1;
  localparam logic signed [QW-1:0] HALF_PI_RAD = 16'sd12868;

  logic             cfg_degrees_mode_r;
  logic [THR_W-1:0] cfg_thr_r;
  logic             adv;

  logic                 fe_vld, sq_vld, cp_vld, cy_vld, cr_vld;
  side_t                fe_side;
  logic [CW-1:0]        sq_c;
  side_t                dl_a [0:SQ_LAT-1];
  pctl_t                cl_a [0:CD_LAT-1];
  vec_t                 pv;
  logic signed [AW-1:0] ang_p, ang_y, ang_r, pitch_sel;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_degrees_mode_r <= 1'b0;
      cfg_thr_r          <= PITCH_THR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEGREES_MODE: cfg_degrees_mode_r <= cfg_data[0];
        REG_PITCH_THR:    cfg_thr_r          <= cfg_data;
        default: ;
      endcase
    end
  end

  q2e_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .vld_in (in_valid),
    .w      (in_quat_w),
    .x      (in_quat_x),
    .y      (in_quat_y),
    .z      (in_quat_z),
    .thr    (cfg_thr_r),
    .vld    (fe_vld),
    .side   (fe_side)
  );

  q2e_isqrt u_isqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .vld_in (fe_vld),
    .s      (fe_side.s),
    .vld    (sq_vld),
    .c      (sq_c)
  );

  // side band waits for the square root
  always_ff @(posedge clk) begin
    if (adv) begin
      dl_a[0] <= fe_side;
      for (int k = 1; k < SQ_LAT; k++) dl_a[k] <= dl_a[k-1];
      cl_a[0] <= dl_a[SQ_LAT-1].ctl;
      for (int k = 1; k < CD_LAT; k++) cl_a[k] <= cl_a[k-1];
    end
  end

  assign pv.y = XW'(dl_a[SQ_LAT-1].s);
  assign pv.x = XW'($signed({1'b0, sq_c}));

  q2e_cordic #(.NSTG(CORDIC_STAGES)) u_cordic_pitch (
    .clk(clk), .rst_n(rst_n), .adv(adv), .vld_in(sq_vld), .v(pv),
    .vld(cp_vld), .ang(ang_p)
  );

  q2e_cordic #(.NSTG(CORDIC_STAGES)) u_cordic_yaw (
    .clk(clk), .rst_n(rst_n), .adv(adv), .vld_in(sq_vld), .v(dl_a[SQ_LAT-1].yaw),
    .vld(cy_vld), .ang(ang_y)
  );

  q2e_cordic #(.NSTG(CORDIC_STAGES)) u_cordic_roll (
    .clk(clk), .rst_n(rst_n), .adv(adv), .vld_in(sq_vld), .v(dl_a[SQ_LAT-1].roll),
    .vld(cr_vld), .ang(ang_r)
  );

  always_comb begin
    if (cl_a[CD_LAT-1].clamped)
      pitch_sel = cl_a[CD_LAT-1].neg ? -HALF_PI_Q30 : HALF_PI_Q30;
    else
      pitch_sel = ang_p;
  end

  q2e_conv u_conv (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .vld_in     (cp_vld),
    .deg        (cfg_degrees_mode_r),
    .pitch_in   (pitch_sel),
    .yaw_in     (ang_y),
    .roll_in    (ang_r),
    .clamped_in (cl_a[CD_LAT-1].clamped),
    .vld        (out_valid),
    .pitch      (out_pitch_angle),
    .yaw        (out_yaw_angle),
    .roll       (out_roll_angle),
    .clamped    (out_pitch_clamped)
  );

  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (cp_vld == cy_vld) && (cp_vld == cr_vld))
    else $error("CORDIC lanes out of step");

  a_clamp_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pitch_clamped && !cfg_degrees_mode_r |->
      (out_pitch_angle == HALF_PI_RAD) || (out_pitch_angle == -HALF_PI_RAD))
    else $error("clamped pitch is not +-pi/2");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid && !fe_vld && !sq_vld)
    else $error("pipeline valid after reset");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(sq_vld) && $stable(cp_vld))
    else $error("pipeline moved during stall");

endmodule

// ----- test/tb.sv -----
// Testbench for the quaternion to Euler angle unit: directed and randomized
// transactions checked against a built-in predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import q2e_pkg::*;

  localparam int STAGES = CORDIC_STAGES_DEF;
  localparam int LATENCY = STAGES + 38;
  localparam longint PI_L = 64'sd3373259426;
  localparam longint HALF_PI_L = 64'sd1686629713;
  localparam longint ONE_L = 64'sd1073741824;

  typedef struct {
    logic signed [15:0] w, x, y, z;
  } quat_t;

  typedef struct {
    logic signed [15:0] pitch, yaw, roll;
    logic clamped;
  } euler_t;

  logic clk, rst_n;
  logic in_valid, in_stall;
  logic signed [15:0] in_quat_w, in_quat_x, in_quat_y, in_quat_z;
  logic out_valid, out_stall;
  logic signed [15:0] out_pitch_angle, out_yaw_angle, out_roll_angle;
  logic out_pitch_clamped;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [THR_W-1:0] cfg_data;

  quaternion_to_euler_angles_unit uut (.*);

  quat_t pending_quats[$];
  euler_t expected_angles[$];
  logic deg_mode;
  longint clamp_thr;
  int mismatches, accepted, results_seen, clamped_seen;
  int burst_left, gap_left;
  logic drain_only;
  logic in_taken;

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint isqrt64(longint d);
    longint res, bit_v;
    res = 0;
    bit_v = 64'sd1 <<< 62;
    while (bit_v > d) bit_v = bit_v >>> 2;
    while (bit_v != 0) begin
      if (d >= res + bit_v) begin
        d = d - (res + bit_v);
        res = (res >>> 1) + bit_v;
      end else begin
        res = res >>> 1;
      end
      bit_v = bit_v >>> 2;
    end
    return res;
  endfunction

  function automatic longint arctan2_q30(longint y, longint x);
    longint ang, xs, ys;
    ang = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      ang = (y >= 0) ? PI_L : -PI_L;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < STAGES && i < TAB_LEN; i++) begin
      xs = floor_shift(x, i);
      ys = floor_shift(y, i);
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        ang = ang + longint'(atan_entry(i));
      end else begin
        x = x - ys;
        y = y + xs;
        ang = ang - longint'(atan_entry(i));
      end
    end
    return ang;
  endfunction

  function automatic logic signed [15:0] scale_angle(longint a);
    longint r;
    if (deg_mode) r = floor_shift(a * 64'sd3754936 + (64'sd1 <<< 38), 39);
    else r = floor_shift(a + (64'sd1 <<< 16), 17);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic euler_t convert_quat(quat_t q);
    euler_t e;
    longint w, x, y, z, p, s, c, pitch;
    w = q.w; x = q.x; y = q.y; z = q.z;
    e.roll = scale_angle(arctan2_q30(2 * (w * z + x * y), ONE_L - 2 * (z * z + x * x)));
    e.yaw = scale_angle(arctan2_q30(2 * (w * y + x * z), ONE_L - 2 * (x * x + y * y)));
    p = w * x - y * z;
    e.clamped = 1'b0;
    if (p < -clamp_thr) begin
      pitch = -HALF_PI_L;
      e.clamped = 1'b1;
    end else if (p > clamp_thr) begin
      pitch = HALF_PI_L;
      e.clamped = 1'b1;
    end else begin
      s = 2 * p;
      if (s > ONE_L) s = ONE_L;
      if (s < -ONE_L) s = -ONE_L;
      c = isqrt64((64'sd1 <<< 60) - s * s);
      pitch = arctan2_q30(s, c);
    end
    e.pitch = scale_angle(pitch);
    return e;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("error at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic add_quat(int w, int x, int y, int z);
    quat_t q;
    q.w = w[15:0]; q.x = x[15:0]; q.y = y[15:0]; q.z = z[15:0];
    pending_quats.push_back(q);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [THR_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_DEGREES_MODE) deg_mode = val[0];
    else if (idx == REG_PITCH_THR) clamp_thr = longint'(val);
  endtask

  // Approximately unit quaternion from random components, with small noise
  task automatic add_unit_quat();
    real a, b, c, n, w, x, y, z;
    a = $urandom_range(0, 65535) / 65535.0 * 2.0 - 1.0;
    b = $urandom_range(0, 65535) / 65535.0 * 2.0 - 1.0;
    c = $urandom_range(0, 65535) / 65535.0 * 2.0 - 1.0;
    w = $urandom_range(0, 65535) / 65535.0 * 2.0 - 1.0;
    if ($urandom_range(0, 7) == 0) begin
      // near gimbal lock: w ~ x, y ~ -z
      x = w; z = -c; y = c; a = 0.0;
      w = w + a;
    end else begin
      x = a; y = b; z = c;
    end
    n = $sqrt(w * w + x * x + y * y + z * z);
    if (n < 0.01) n = 1.0;
    add_quat(int'(w / n * 32767.0) + $urandom_range(0, 6) - 3,
             int'(x / n * 32767.0) + $urandom_range(0, 6) - 3,
             int'(y / n * 32767.0) + $urandom_range(0, 6) - 3,
             int'(z / n * 32767.0) + $urandom_range(0, 6) - 3);
  endtask

  task automatic run_phase(int n_items);
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 4) == 0)
        add_quat($urandom, $urandom, $urandom, $urandom);
      else
        add_unit_quat();
    end
    wait (pending_quats.size() == 0 && expected_angles.size() == 0);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // hold the stalled transaction
    end else begin
      if (burst_left == 0 && gap_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end
      if (gap_left > 0 && !drain_only) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_quats.size() > 0) begin
        if (burst_left > 0) burst_left--;
        in_valid <= 1'b1;
        in_quat_w <= pending_quats[0].w;
        in_quat_x <= pending_quats[0].x;
        in_quat_y <= pending_quats[0].y;
        in_quat_z <= pending_quats[0].z;
        expected_angles.push_back(convert_quat(pending_quats[0]));
        void'(pending_quats.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern: phases of heavy, light and no stalling
  always @(negedge clk) begin
    int phase_mode;
    phase_mode = (accepted / 97) % 3;
    if (!rst_n) out_stall <= 1'b0;
    else if (phase_mode == 0) out_stall <= 1'b0;
    else if (phase_mode == 1) out_stall <= ($urandom_range(0, 3) == 0);
    else out_stall <= ($urandom_range(0, 2) != 0);
  end

  // Monitor
  always @(posedge clk) begin
    euler_t e;
    in_taken = rst_n && in_valid && !in_stall;
    if (in_taken) accepted++;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_angles.size() == 0) begin
        report_mismatch("unexpected transaction", 0, 0);
      end else begin
        e = expected_angles.pop_front();
        if (out_pitch_angle !== e.pitch) report_mismatch("pitch", out_pitch_angle, e.pitch);
        if (out_yaw_angle !== e.yaw) report_mismatch("yaw", out_yaw_angle, e.yaw);
        if (out_roll_angle !== e.roll) report_mismatch("roll", out_roll_angle, e.roll);
        if (out_pitch_clamped !== e.clamped)
          report_mismatch("pitch_clamped", out_pitch_clamped, e.clamped);
        if (e.clamped) clamped_seen++;
      end
    end
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_taken = 1'b0;
    in_quat_w = '0; in_quat_x = '0; in_quat_y = '0; in_quat_z = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatches = 0; accepted = 0; results_seen = 0; clamped_seen = 0;
    burst_left = 0; gap_left = 0;
    drain_only = 1'b0;
    deg_mode = 1'b0;
    clamp_thr = longint'(PITCH_THR_RESET);
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: axes, extremes, zero vector, negative x axis, gimbal lock
    add_quat(32767, 0, 0, 0);
    add_quat(0, 0, 0, 0);
    add_quat(-32768, -32768, -32768, -32768);
    add_quat(32767, 32767, 32767, 32767);
    add_quat(-32768, 32767, -32768, 32767);
    add_quat(0, 32767, 0, 0);
    add_quat(0, 0, 32767, 0);
    add_quat(0, 0, 0, 32767);
    add_quat(0, 0, 0, -32768);
    add_quat(23170, 23170, 0, 0);
    add_quat(23170, -23170, 0, 0);
    add_quat(0, 0, 23170, -23170);
    add_quat(23170, 23170, 100, 100);
    add_quat(16384, 16384, -16384, 16384);
    add_quat(23169, 23169, 1, 0);
    add_quat(-1, 1, -1, 1);
    add_quat(32767, 32767, 0, 0);
    run_phase(0);

    write_reg(REG_DEGREES_MODE, 1);
    add_quat(23170, 23170, 0, 0);
    add_quat(0, 0, 0, 32767);
    add_quat(-32768, 32767, -32768, 32767);
    add_quat(16384, 16384, -16384, 16384);
    run_phase(250);

    write_reg(REG_PITCH_THR, 0);
    run_phase(200);
    write_reg(REG_PITCH_THR, 31'h7FFFFFFF);
    write_reg(REG_DEGREES_MODE, 0);
    add_quat(32767, 32767, 0, 0);
    add_quat(-32768, 32767, 32767, 32767);
    run_phase(200);
    write_reg(REG_PITCH_THR, 31'd1073741824);
    write_reg(REG_DEGREES_MODE, 1);
    run_phase(150);
    write_reg(REG_PITCH_THR, 31'd268435456);
    write_reg(REG_DEGREES_MODE, 0);
    run_phase(200);

    $display("covered %0d transactions (%0d clamped) over radian/degree modes",
             results_seen, clamped_seen);
    $display("and clamp thresholds from zero to the register maximum");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
